### rtl/xor_checked_frame_receiver_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the XOR-checked frame receiver
// Implication forms used by the RTL; clk and rst_n come from the module.
// ---------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication
`define XCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define XCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xcfr_pkg.sv
// ---------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants of the XOR-checked frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

  // Default byte count at which a frame is abandoned
  localparam int MAX_FRAME_BYTES_DEF = 255;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;

  // Per-word frame status
  typedef enum logic [2:0] {
    ST_MID     = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ABANDON = 3'd4
  } status_t;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  position;
    status_t            frame_status;
    logic [COUNT_W-1:0] error_total;
  } result_t;

endpackage

`default_nettype wire

### rtl/xcfr_if.sv
// ---------------------------------------------------------------------------
// xcfr_in_if / xcfr_out_if
// Valid/ready channels for received bytes and for result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface xcfr_in_if import xcfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfr_out_if import xcfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic [BYTE_W-1:0]  position;
  logic [2:0]         frame_status;
  logic [COUNT_W-1:0] error_total;

  modport source (output valid, output data_byte, output position,
                  output frame_status, output error_total, input ready);
  modport sink   (input valid, input data_byte, input position,
                  input frame_status, input error_total, output ready);
endinterface

`default_nettype wire

### rtl/xcfr_frame_core.sv
// ---------------------------------------------------------------------------
// xcfr_frame_core
// Frame state (count, XOR, length, error counter) and per-byte decode.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_receiver_top_macros.svh"

module xcfr_frame_core
  import xcfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output result_t                res
);

  logic [BYTE_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]  xor_r, xor_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [COUNT_W-1:0] err_r, err_nxt;

  logic [BYTE_W:0]    taken;
  status_t            status;

  // Decode of one byte against the current frame state
  always_comb begin
    len_nxt   = (count_r == '0) ? rx_byte : len_r;
    taken     = {1'b0, count_r} + (BYTE_W+1)'(1);
    count_nxt = '0;
    xor_nxt   = '0;
    err_nxt   = err_r;
    if (taken >= (BYTE_W+1)'(MAX_FRAME_BYTES)) begin
      status = ST_ABANDON;
    end else if (taken <= {1'b0, len_nxt}) begin
      status    = ST_MID;
      count_nxt = taken[BYTE_W-1:0];
      xor_nxt   = xor_r ^ rx_byte;
    end else if (len_nxt == '0) begin
      status = ST_EMPTY;
    end else if (rx_byte == xor_r) begin
      status = ST_GOOD;
    end else begin
      status  = ST_BAD;
      err_nxt = err_r + COUNT_W'(1);
    end
  end

  assign res.data_byte    = rx_byte;
  assign res.position     = count_r;
  assign res.frame_status = status;
  assign res.error_total  = err_nxt;

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
      len_r   <= '0;
      err_r   <= '0;
    end else if (take) begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      len_r   <= len_nxt;
      err_r   <= err_nxt;
    end
  end

  `XCFR_ASSERT_NOW(a_count_below_max, 1'b1, {1'b0, count_r} < (BYTE_W+1)'(MAX_FRAME_BYTES), "byte count reached abandon limit")
  `XCFR_ASSERT_NEXT(a_bad_counts, take && (status == ST_BAD), err_r == $past(err_r) + COUNT_W'(1), "bad checksum not counted")
  `XCFR_ASSERT_NEXT(a_end_restarts, take && (status != ST_MID), (count_r == '0) && (xor_r == '0), "frame did not restart after end")

endmodule

`default_nettype wire

### rtl/xcfr_out_skid.sv
// ---------------------------------------------------------------------------
// xcfr_out_skid
// Two-entry result buffer: output register plus skid stage.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_receiver_top_macros.svh"

module xcfr_out_skid
  import xcfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_res,
  output logic         can_push,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;
  assign pop       = main_v_r && out_ready;

  // Buffer steering
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!main_v_r || pop) begin
      if (push) begin
        main_nxt   = push_res;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_res;
      skid_v_nxt = 1'b1;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `XCFR_ASSERT_NOW(a_skid_needs_main, skid_v_r, main_v_r, "skid full while output empty")
  `XCFR_ASSERT_NEXT(a_stall_fills_skid, push && main_v_r && !out_ready, skid_v_r, "stalled word not held in skid")
  `XCFR_ASSERT_NEXT(a_skid_drains, skid_v_r && out_ready, main_v_r && !skid_v_r, "skid word not moved to output")

endmodule

`default_nettype wire

### rtl/xor_checked_frame_receiver_top.sv
// Each byte is decoded in a single pass and its result word is registered in the output buffer.
// Throughput: one byte per cycle while the skid entry is empty (input ready high).
// A two-entry output buffer keeps input ready high for one stalled result.
// Reset (rst_n low, synchronous) clears frame count, XOR, length, error counter and buffer.
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver_top
// Length-prefixed XOR-checksum deframer with bad-checksum counter.
// ---------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_top
  import xcfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  xcfr_in_if.sink    in_chan,
  xcfr_out_if.source out_chan
);

  logic    take;
  logic    can_push;
  result_t res;
  result_t out_res;

  // Input handshake
  assign in_chan.ready = can_push;
  assign take          = in_chan.valid && can_push;

  xcfr_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_chan.rx_byte),
    .res     (res)
  );

  xcfr_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_res  (res),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // Result word onto the channel
  assign out_chan.data_byte    = out_res.data_byte;
  assign out_chan.position     = out_res.position;
  assign out_chan.frame_status = out_res.frame_status;
  assign out_chan.error_total  = out_res.error_total;

endmodule

`default_nettype wire

### sim/xcfr_frame_checker.sv
// ---------------------------------------------------------------------------
// xcfr_frame_checker
// Watches the byte and result channels of the XOR-checked frame receiver,
// predicts each result word from the accepted bytes and compares in order.
// ---------------------------------------------------------------------------
`default_nettype none

module xcfr_frame_checker
  import xcfr_pkg::*;
#(
  parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  xcfr_in_if       in_mon,
  xcfr_out_if      out_mon,
  output int       fail_count,
  output int       words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted deframer state
  logic [BYTE_W-1:0]  byte_cnt;
  logic [BYTE_W-1:0]  xor_acc;
  logic [BYTE_W-1:0]  frame_len;
  logic [COUNT_W-1:0] bad_frames;

  // Result words still owed by the block, oldest first
  result_t owed_words[$];

  task automatic report_failure(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  // Advance the frame state by one received byte and build its result word
  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    int      taken;
    r.data_byte = b;
    r.position  = byte_cnt;
    taken       = int'(byte_cnt) + 1;
    if (byte_cnt == '0) frame_len = b;
    if (taken >= MAX_BYTES) begin
      // overlong frame: drop this byte and start over
      r.frame_status = ST_ABANDON;
      byte_cnt       = '0;
      xor_acc        = '0;
    end else if (taken <= int'(frame_len)) begin
      xor_acc        = xor_acc ^ b;
      byte_cnt       = BYTE_W'(taken);
      r.frame_status = ST_MID;
    end else begin
      // frame end: length byte alone, or checksum byte
      if (frame_len == '0) begin
        r.frame_status = ST_EMPTY;
      end else if (b == xor_acc) begin
        r.frame_status = ST_GOOD;
      end else begin
        r.frame_status = ST_BAD;
        bad_frames     = bad_frames + COUNT_W'(1);
      end
      byte_cnt = '0;
      xor_acc  = '0;
    end
    r.error_total = bad_frames;
    return r;
  endfunction

  // Compare result words first, then queue the prediction for a new byte
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      byte_cnt   = '0;
      xor_acc    = '0;
      frame_len  = '0;
      bad_frames = '0;
      owed_words.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (owed_words.size() == 0) begin
          report_failure($sformatf("result word 0x%0h with none expected", out_mon.data_byte));
        end else begin
          want = owed_words.pop_front();
          if (out_mon.data_byte !== want.data_byte)
            report_failure($sformatf("data_byte got 0x%0h, expected 0x%0h",
                                     out_mon.data_byte, want.data_byte));
          if (out_mon.position !== want.position)
            report_failure($sformatf("position got %0d, expected %0d",
                                     out_mon.position, want.position));
          if (out_mon.frame_status !== want.frame_status)
            report_failure($sformatf("frame_status got %0d, expected %s (byte 0x%0h pos %0d)",
                                     out_mon.frame_status, want.frame_status.name(),
                                     want.data_byte, want.position));
          if (out_mon.error_total !== want.error_total)
            report_failure($sformatf("error_total got %0d, expected %0d",
                                     out_mon.error_total, want.error_total));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        owed_words.push_back(deframe_byte(in_mon.rx_byte));
    end
    words_pending = owed_words.size();
  end

endmodule

`default_nettype wire

### sim/xor_checked_frame_receiver_top_tb.sv
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver_top_tb
// Drives framed byte streams (empty, good, bad-checksum and overlong frames
// plus loose noise bytes) into the receiver with random idling on both
// channels and one long output hold-off; the checker scores every word.
// ---------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_top_tb
  import xcfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL    = 1800;    // bytes in the whole run
  localparam int CALM_FROM    = 1600;    // no idling after this many bytes
  localparam int HOLD_AT      = 600;     // byte count that triggers the hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst_n;

  xcfr_in_if  in_chan ();
  xcfr_out_if out_chan ();

  int fail_count;
  int words_pending;
  int bytes_sent    = 0;
  int cycle_count   = 0;
  bit idling_on     = 1'b1;
  bit hold_off_done = 1'b0;

  xor_checked_frame_receiver_top #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES_DEF)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  xcfr_frame_checker #(
    .MAX_BYTES(MAX_FRAME_BYTES_DEF)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one word, with an optional idle burst ahead of it
  task automatic send_word(input logic [BYTE_W-1:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    bytes_sent++;
    if (bytes_sent == CALM_FROM) idling_on = 1'b0;
  endtask

  // Length byte, len-1 payload bytes, then the checksum (none for len 0)
  task automatic send_frame(input int len, input fill_t fill, input bit corrupt);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] d;
    acc = BYTE_W'(len);
    send_word(BYTE_W'(len));
    for (int i = 1; i < len; i++) begin
      case (fill)
        FILL_ZERO: d = '0;
        FILL_ONES: d = '1;
        default:   d = BYTE_W'($urandom);
      endcase
      acc = acc ^ d;
      send_word(d);
    end
    if (len > 0)
      send_word(corrupt ? acc ^ BYTE_W'($urandom_range(1, 255)) : acc);
  endtask

  // Result side: random stalls, one long hold-off while bytes keep coming
  initial begin
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!hold_off_done && bytes_sent >= HOLD_AT) begin
        hold_off_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int pick;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.rx_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, shortest frames, all-zero and all-one payloads
    send_frame(0, FILL_RANDOM, 1'b0);
    send_frame(1, FILL_RANDOM, 1'b0);
    send_frame(1, FILL_RANDOM, 1'b1);
    send_frame(2, FILL_ONES, 1'b0);
    send_frame(2, FILL_ZERO, 1'b1);
    send_frame(3, FILL_ONES, 1'b0);
    send_frame(3, FILL_ZERO, 1'b0);
    send_frame(0, FILL_RANDOM, 1'b0);

    // longest frame that still ends normally, then an abandoned one
    send_frame(MAX_FRAME_BYTES_DEF - 2, FILL_RANDOM, $urandom_range(0, 1));
    send_frame($urandom_range(MAX_FRAME_BYTES_DEF - 1, 255), FILL_RANDOM, 1'b0);

    // random frames, mostly well formed, some broken, some loose bytes
    while (bytes_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 149);
      if (pick == 0)
        send_frame($urandom_range(240, 255), FILL_RANDOM, $urandom_range(0, 1));
      else if (pick < 120)
        send_frame($urandom_range(0, 20), FILL_RANDOM, $urandom_range(0, 4) == 0);
      else if (pick < 130)
        send_frame($urandom_range(1, 6), $urandom_range(0, 1) ? FILL_ONES : FILL_ZERO,
                   $urandom_range(0, 1));
      else
        repeat ($urandom_range(1, 4)) send_word(BYTE_W'($urandom));
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/xcfr_pkg.sv
rtl/xcfr_if.sv
rtl/xcfr_frame_core.sv
rtl/xcfr_out_skid.sv
rtl/xor_checked_frame_receiver_top.sv
sim/xcfr_frame_checker.sv
sim/xor_checked_frame_receiver_top_tb.sv
